/* rtl/mcfe_pkg.sv */
`default_nettype none

package mcfe_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] op_code_t;

    // payload store depth and the width of the length / position counter
    localparam int PAY_MAX = 12;
    localparam int CNT_W   = 4;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam byte_t HEADER_BYTE  = 8'h3E;
    localparam byte_t ADDR_RESET   = 8'h01;
    localparam byte_t FILL_BYTE    = 8'h00;

    // request operation codes
    localparam op_code_t OP_PID_RAM  = 4'd0;
    localparam op_code_t OP_PID_ROM  = 4'd1;
    localparam op_code_t OP_STOP     = 4'd2;
    localparam op_code_t OP_PAUSE    = 4'd3;
    localparam op_code_t OP_RESUME   = 4'd4;
    localparam op_code_t OP_READ     = 4'd5;
    localparam op_code_t OP_POWER    = 4'd6;
    localparam op_code_t OP_VEL      = 4'd7;
    localparam op_code_t OP_MULTI1   = 4'd8;
    localparam op_code_t OP_MULTI2   = 4'd9;
    localparam op_code_t OP_SINGLE1  = 4'd10;
    localparam op_code_t OP_SINGLE2  = 4'd11;
    localparam op_code_t OP_INCR1    = 4'd12;
    localparam op_code_t OP_INCR2    = 4'd13;

    // command bytes on the wire
    localparam byte_t CMD_PID_RAM  = 8'h31;
    localparam byte_t CMD_PID_ROM  = 8'h32;
    localparam byte_t CMD_STOP     = 8'h80;
    localparam byte_t CMD_PAUSE    = 8'h81;
    localparam byte_t CMD_RESUME   = 8'h88;
    localparam byte_t CMD_READ     = 8'h9C;
    localparam byte_t CMD_POWER    = 8'hA0;
    localparam byte_t CMD_VEL      = 8'hA2;
    localparam byte_t CMD_MULTI1   = 8'hA3;
    localparam byte_t CMD_MULTI2   = 8'hA4;
    localparam byte_t CMD_SINGLE1  = 8'hA5;
    localparam byte_t CMD_SINGLE2  = 8'hA6;
    localparam byte_t CMD_INCR1    = 8'hA7;
    localparam byte_t CMD_INCR2    = 8'hA8;

    // header byte positions
    localparam cnt_t POS_HDR  = 4'd0;
    localparam cnt_t POS_CODE = 4'd1;
    localparam cnt_t POS_ADDR = 4'd2;
    localparam cnt_t POS_LEN  = 4'd3;
    localparam cnt_t POS_HSUM = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_BODY,
        ST_DSUM
    } state_t;

    typedef struct packed {
        logic   busy;
        state_t state;
        cnt_t   pos;
        cnt_t   plen;
        logic   last;
        logic   load;
        logic   shift;
        logic   acc_clr;
        logic   acc_add;
    } ctl_t;

    function automatic logic op_valid(input op_code_t op);
        return (op <= OP_INCR2);
    endfunction

    function automatic byte_t cmd_code(input op_code_t op);
        byte_t c;
        c = FILL_BYTE;
        unique case (op)
            OP_PID_RAM: c = CMD_PID_RAM;
            OP_PID_ROM: c = CMD_PID_ROM;
            OP_STOP:    c = CMD_STOP;
            OP_PAUSE:   c = CMD_PAUSE;
            OP_RESUME:  c = CMD_RESUME;
            OP_READ:    c = CMD_READ;
            OP_POWER:   c = CMD_POWER;
            OP_VEL:     c = CMD_VEL;
            OP_MULTI1:  c = CMD_MULTI1;
            OP_MULTI2:  c = CMD_MULTI2;
            OP_SINGLE1: c = CMD_SINGLE1;
            OP_SINGLE2: c = CMD_SINGLE2;
            OP_INCR1:   c = CMD_INCR1;
            OP_INCR2:   c = CMD_INCR2;
            default:    c = FILL_BYTE;
        endcase
        return c;
    endfunction

    function automatic cnt_t pay_len(input op_code_t op);
        cnt_t n;
        n = 4'd0;
        unique case (op) inside
            OP_PID_RAM, OP_PID_ROM:        n = 4'd6;
            OP_POWER:                      n = 4'd2;
            OP_VEL, OP_INCR1, OP_SINGLE1:  n = 4'd4;
            OP_MULTI1, OP_INCR2, OP_SINGLE2: n = 4'd8;
            OP_MULTI2:                     n = 4'd12;
            default:                       n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/motor_command_frame_encoder_unit.sv */
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------------
// in      | in        | in_valid / in_stall   | operation, target_value, direction,
//         |           |                     | max_speed, gain_* (one request per beat)
// out     | out       | out_valid / out_stall | frame_byte, last_byte (one byte per beat)
// cfg     | in        | cfg_write_en        | cfg_write_data -> motor id byte
//
// a request beat starts a frame of 5 to 18 bytes; the sequencer emits one byte per
// cycle while out_stall is low
// the single 8-bit accumulator builds both checksums in turn as bytes leave
// in_stall stays high after the request beat until the last byte has been taken
// requests with an unused operation code are taken and produce no bytes
// reset clears the sequencer and loads motor id 1
`default_nettype none

module motor_command_frame_encoder_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         operation,
    input  wire logic signed [63:0] target_value,
    input  wire logic [7:0]         direction,
    input  wire logic [31:0]        max_speed,
    input  wire logic [7:0]         gain_pos_p,
    input  wire logic [7:0]         gain_pos_i,
    input  wire logic [7:0]         gain_vel_p,
    input  wire logic [7:0]         gain_vel_i,
    input  wire logic [7:0]         gain_trq_p,
    input  wire logic [7:0]         gain_trq_i,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              frame_byte,
    output logic                    last_byte,

    input  wire logic               cfg_write_en,
    input  wire logic [7:0]         cfg_write_data
);
    import mcfe_pkg::*;

    ctl_t  ctl;
    logic  in_fire;
    logic  out_fire;
    byte_t addr_reg;
    byte_t code_reg;
    byte_t pay_head;
    byte_t acc_sum;
    byte_t byte_mux;

    // busy while any byte of the current frame is still pending
    assign in_stall  = ctl.busy;
    assign out_valid = ctl.busy;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;

    // motor id register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else if (cfg_write_en)
        begin
            addr_reg <= cfg_write_data;
        end
    end

    // command byte held for the frame
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            code_reg <= cmd_code(operation);
        end
    end

    mcfe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .operation (operation),
        .ctl       (ctl)
    );

    mcfe_pay u_pay (
        .clk          (clk),
        .load         (ctl.load),
        .shift        (ctl.shift),
        .operation    (operation),
        .target_value (target_value),
        .direction    (direction),
        .max_speed    (max_speed),
        .gain_pos_p   (gain_pos_p),
        .gain_pos_i   (gain_pos_i),
        .gain_vel_p   (gain_vel_p),
        .gain_vel_i   (gain_vel_i),
        .gain_trq_p   (gain_trq_p),
        .gain_trq_i   (gain_trq_i),
        .pay_head     (pay_head)
    );

    // checksum accumulator sums the bytes that leave since the frame start or the last checksum
    mcfe_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (ctl.acc_clr),
        .add   (ctl.acc_add),
        .din   (byte_mux),
        .sum   (acc_sum)
    );

    // current frame byte
    always_comb
    begin
        byte_mux = FILL_BYTE;
        case (ctl.state)
            ST_HEAD:
            begin
                case (ctl.pos)
                    POS_HDR:  byte_mux = HEADER_BYTE;
                    POS_CODE: byte_mux = code_reg;
                    POS_ADDR: byte_mux = addr_reg;
                    POS_LEN:  byte_mux = {4'd0, ctl.plen};
                    POS_HSUM: byte_mux = acc_sum;
                    default:  byte_mux = FILL_BYTE;
                endcase
            end
            ST_BODY: byte_mux = pay_head;
            ST_DSUM: byte_mux = acc_sum;
            default: byte_mux = FILL_BYTE;
        endcase
    end

    assign frame_byte = byte_mux;
    assign last_byte  = ctl.last;

endmodule

`default_nettype wire

/* rtl/mcfe_acc.sv */
`default_nettype none

module mcfe_acc (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clr,
    input  wire logic           add,
    input  wire mcfe_pkg::byte_t din,
    output mcfe_pkg::byte_t     sum
);
    import mcfe_pkg::*;

    byte_t acc_reg;
    byte_t acc_next;

    // shared 8-bit adder, wraps mod 256
    always_comb
    begin
        acc_next = acc_reg;
        if (clr)
        begin
            acc_next = 8'h00;
        end
        else if (add)
        begin
            acc_next = acc_reg + din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'h00;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum = acc_reg;

endmodule

`default_nettype wire

/* rtl/mcfe_pay.sv */
`default_nettype none

module mcfe_pay (
    input  wire logic                clk,
    input  wire logic                load,
    input  wire logic                shift,
    input  wire mcfe_pkg::op_code_t  operation,
    input  wire logic signed [63:0]  target_value,
    input  wire mcfe_pkg::byte_t     direction,
    input  wire logic [31:0]         max_speed,
    input  wire mcfe_pkg::byte_t     gain_pos_p,
    input  wire mcfe_pkg::byte_t     gain_pos_i,
    input  wire mcfe_pkg::byte_t     gain_vel_p,
    input  wire mcfe_pkg::byte_t     gain_vel_i,
    input  wire mcfe_pkg::byte_t     gain_trq_p,
    input  wire mcfe_pkg::byte_t     gain_trq_i,
    output mcfe_pkg::byte_t          pay_head
);
    import mcfe_pkg::*;

    byte_t pay_reg  [PAY_MAX];
    byte_t pay_next [PAY_MAX];
    byte_t build    [PAY_MAX];

    // little-endian payload image per command
    always_comb
    begin
        for (int i = 0; i < PAY_MAX; i++)
        begin
            build[i] = FILL_BYTE;
        end
        case (operation) inside
            OP_PID_RAM, OP_PID_ROM:
            begin
                build[0] = gain_pos_p;
                build[1] = gain_pos_i;
                build[2] = gain_vel_p;
                build[3] = gain_vel_i;
                build[4] = gain_trq_p;
                build[5] = gain_trq_i;
            end
            OP_POWER:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    build[i] = target_value[8*i +: 8];
                end
            end
            OP_VEL, OP_INCR1, OP_INCR2:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    build[i]     = target_value[8*i +: 8];
                    build[i + 4] = (operation == OP_INCR2) ? max_speed[8*i +: 8] : FILL_BYTE;
                end
            end
            OP_MULTI1, OP_MULTI2:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    build[i] = target_value[8*i +: 8];
                end
                for (int i = 0; i < 4; i++)
                begin
                    build[i + 8] = (operation == OP_MULTI2) ? max_speed[8*i +: 8] : FILL_BYTE;
                end
            end
            OP_SINGLE1, OP_SINGLE2:
            begin
                build[0] = direction;
                build[1] = target_value[7:0];
                build[2] = target_value[15:8];
                build[3] = FILL_BYTE;
                for (int i = 0; i < 4; i++)
                begin
                    build[i + 4] = (operation == OP_SINGLE2) ? max_speed[8*i +: 8] : FILL_BYTE;
                end
            end
            default:
            begin
                build[0] = FILL_BYTE;
            end
        endcase
    end

    // load a fresh image, or shift one byte toward the head per payload beat
    always_comb
    begin
        for (int i = 0; i < PAY_MAX; i++)
        begin
            pay_next[i] = pay_reg[i];
        end
        if (load)
        begin
            for (int i = 0; i < PAY_MAX; i++)
            begin
                pay_next[i] = build[i];
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < PAY_MAX - 1; i++)
            begin
                pay_next[i] = pay_reg[i + 1];
            end
            pay_next[PAY_MAX-1] = FILL_BYTE;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PAY_MAX; i++)
        begin
            pay_reg[i] <= pay_next[i];
        end
    end

    assign pay_head = pay_reg[0];

endmodule

`default_nettype wire

/* rtl/mcfe_seq.sv */
`default_nettype none

module mcfe_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               out_fire,
    input  wire mcfe_pkg::op_code_t operation,
    output mcfe_pkg::ctl_t          ctl
);
    import mcfe_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   cnt_reg;
    cnt_t   cnt_next;
    cnt_t   plen_reg;
    cnt_t   plen_next;
    logic   start;
    logic   hsum_pos;

    assign start    = in_fire && op_valid(operation);
    assign hsum_pos = (cnt_reg == POS_HSUM);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        plen_next  = plen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HEAD;
                    cnt_next   = POS_HDR;
                    plen_next  = pay_len(operation);
                end
            end
            ST_HEAD:
            begin
                if (out_fire)
                begin
                    if (hsum_pos)
                    begin
                        state_next = (plen_reg == 4'd0) ? ST_IDLE : ST_BODY;
                        cnt_next   = plen_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_BODY:
            begin
                if (out_fire)
                begin
                    if (cnt_reg == 4'd1)
                    begin
                        state_next = ST_DSUM;
                    end
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_DSUM:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl         = '0;
        ctl.state   = state_reg;
        ctl.pos     = cnt_reg;
        ctl.plen    = plen_reg;
        ctl.load    = start && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.acc_clr = start;
            end
            ST_HEAD:
            begin
                ctl.busy    = 1'b1;
                ctl.last    = hsum_pos && (plen_reg == 4'd0);
                ctl.acc_clr = out_fire && hsum_pos;
                ctl.acc_add = out_fire && !hsum_pos;
            end
            ST_BODY:
            begin
                ctl.busy    = 1'b1;
                ctl.shift   = out_fire;
                ctl.acc_add = out_fire;
            end
            ST_DSUM:
            begin
                ctl.busy = 1'b1;
                ctl.last = 1'b1;
            end
            default:
            begin
                ctl.busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= POS_HDR;
            plen_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            plen_reg  <= plen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_body_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BODY |-> cnt_reg != 4'd0)
        else $error("payload count ran out inside body");

    a_head_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HEAD |-> cnt_reg <= POS_HSUM)
        else $error("header position past checksum");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && ctl.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after last beat");

    a_plen_legal: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg == 4'd0 || plen_reg == 4'd2 || plen_reg == 4'd4 ||
        plen_reg == 4'd6 || plen_reg == 4'd8 || plen_reg == 4'd12)
        else $error("illegal payload length latched");
`endif

endmodule

`default_nettype wire

/* dv/frame_checker.sv */
`timescale 1ns / 1ps

module frame_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [3:0]         operation,
    input  wire logic signed [63:0] target_value,
    input  wire logic [7:0]         direction,
    input  wire logic [31:0]        max_speed,
    input  wire logic [7:0]         gain_pos_p,
    input  wire logic [7:0]         gain_pos_i,
    input  wire logic [7:0]         gain_vel_p,
    input  wire logic [7:0]         gain_vel_i,
    input  wire logic [7:0]         gain_trq_p,
    input  wire logic [7:0]         gain_trq_i,

    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [7:0]         frame_byte,
    input  wire logic               last_byte,

    input  wire logic               cfg_write_en,
    input  wire logic [7:0]         cfg_write_data,

    output int                      fail_count,
    output int                      pending
);
    import mcfe_pkg::*;

    typedef struct packed {
        byte_t data;
        logic  last;
    } frame_beat_t;

    frame_beat_t frame_bytes_due [$];
    byte_t       drive_addr;
    int          beat_index;

    function automatic void push_beat(input byte_t b, input logic last);
        frame_beat_t fb;
        fb.data = b;
        fb.last = last;
        frame_bytes_due.push_back(fb);
    endfunction

    // builds the expected frame of one request, bytes in wire order
    function automatic void predict_frame(input op_code_t op, input logic [63:0] tv,
                                          input byte_t dir, input logic [31:0] spd,
                                          input logic [47:0] gains, input byte_t id);
        logic [95:0] body;
        int          plen;
        byte_t       code;
        byte_t       hsum;
        byte_t       dsum;
        int          k;
        body = '0;
        plen = 0;
        code = FILL_BYTE;
        case (op)
            OP_PID_RAM:  begin code = CMD_PID_RAM; body = 96'(gains); plen = 6; end
            OP_PID_ROM:  begin code = CMD_PID_ROM; body = 96'(gains); plen = 6; end
            OP_STOP:     code = CMD_STOP;
            OP_PAUSE:    code = CMD_PAUSE;
            OP_RESUME:   code = CMD_RESUME;
            OP_READ:     code = CMD_READ;
            OP_POWER:    begin code = CMD_POWER; body = 96'(tv); plen = 2; end
            OP_VEL:      begin code = CMD_VEL; body = 96'(tv); plen = 4; end
            OP_MULTI1:   begin code = CMD_MULTI1; body = 96'(tv); plen = 8; end
            OP_MULTI2:   begin code = CMD_MULTI2; body = {spd, tv}; plen = 12; end
            OP_SINGLE1:
            begin
                code = CMD_SINGLE1;
                body = 96'({FILL_BYTE, tv[15:0], dir});
                plen = 4;
            end
            OP_SINGLE2:
            begin
                code = CMD_SINGLE2;
                body = 96'({spd, FILL_BYTE, tv[15:0], dir});
                plen = 8;
            end
            OP_INCR1:    begin code = CMD_INCR1; body = 96'(tv); plen = 4; end
            OP_INCR2:    begin code = CMD_INCR2; body = 96'({spd, tv[31:0]}); plen = 8; end
            default:     return;  // unused code, no frame
        endcase
        hsum = HEADER_BYTE + code + id + byte_t'(plen);
        push_beat(HEADER_BYTE, 1'b0);
        push_beat(code, 1'b0);
        push_beat(id, 1'b0);
        push_beat(byte_t'(plen), 1'b0);
        push_beat(hsum, plen == 0);
        if (plen > 0)
        begin
            dsum = '0;
            for (k = 0; k < plen; k++)
            begin
                push_beat(body[8*k +: 8], 1'b0);
                dsum = dsum + body[8*k +: 8];
            end
            push_beat(dsum, 1'b1);
        end
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        beat_index = 0;
        drive_addr = ADDR_RESET;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_beat_t due;
        if (!rst_n)
        begin
            drive_addr = ADDR_RESET;
        end
        else
        begin
            if (cfg_write_en)
                drive_addr = cfg_write_data;
            if (in_valid && !in_stall)
                predict_frame(op_code_t'(operation), target_value, direction, max_speed,
                              {gain_trq_i, gain_trq_p, gain_vel_i, gain_vel_p,
                               gain_pos_i, gain_pos_p}, drive_addr);
            if (out_valid && !out_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t: beat %0d unexpected, expected none, actual %02h last %0b",
                             $time, beat_index, frame_byte, last_byte);
                    fail_count++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame_byte !== due.data)
                    begin
                        $display("%0t: beat %0d frame_byte expected %02h actual %02h",
                                 $time, beat_index, due.data, frame_byte);
                        fail_count++;
                    end
                    if (last_byte !== due.last)
                    begin
                        $display("%0t: beat %0d last_byte expected %0b actual %0b",
                                 $time, beat_index, due.last, last_byte);
                        fail_count++;
                    end
                end
                beat_index++;
            end
            pending = frame_bytes_due.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mcfe_pkg::*;

    // run shape
    localparam int        HALF_PERIOD = 4;
    localparam int        RESET_CYCLES = 7;
    localparam int        CFG_SETTLE = 24;        // settle time before a motor id write
    localparam int        HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int        DRAIN_LIMIT = 4000;
    localparam int        TAIL_CYCLES = 40;
    localparam longint    RUN_LIMIT_NS = 3_000_000;

    // one request as the sender sees it; gains[0] is the position p gain
    typedef struct packed {
        op_code_t           op;
        logic signed [63:0] tv;
        byte_t              dir;
        logic [31:0]        spd;
        logic [5:0][7:0]    gains;
    } motor_req_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         operation;
    logic signed [63:0] target_value;
    logic [7:0]         direction;
    logic [31:0]        max_speed;
    logic [7:0]         gain_pos_p;
    logic [7:0]         gain_pos_i;
    logic [7:0]         gain_vel_p;
    logic [7:0]         gain_vel_i;
    logic [7:0]         gain_trq_p;
    logic [7:0]         gain_trq_i;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         frame_byte;
    logic               last_byte;
    logic               cfg_write_en;
    logic [7:0]         cfg_write_data;

    int                 fail_count;
    int                 pending;

    // set by the stimulus, read by the receiver process
    bit                 calm;           // no idling on either side
    bit                 hold_off_due;   // receiver should do its long hold-off

    motor_command_frame_encoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .target_value   (target_value),
        .direction      (direction),
        .max_speed      (max_speed),
        .gain_pos_p     (gain_pos_p),
        .gain_pos_i     (gain_pos_i),
        .gain_vel_p     (gain_vel_p),
        .gain_vel_i     (gain_vel_i),
        .gain_trq_p     (gain_trq_p),
        .gain_trq_i     (gain_trq_i),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // watches all three channels, predicts every frame and compares
    frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .target_value   (target_value),
        .direction      (direction),
        .max_speed      (max_speed),
        .gain_pos_p     (gain_pos_p),
        .gain_pos_i     (gain_pos_i),
        .gain_vel_p     (gain_vel_p),
        .gain_vel_i     (gain_vel_i),
        .gain_trq_p     (gain_trq_p),
        .gain_trq_i     (gain_trq_i),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // request with random content everywhere, including fields the command ignores
    function automatic motor_req_t rand_req(input op_code_t op);
        motor_req_t r;
        int         k;
        r.op  = op;
        r.tv  = {$urandom, $urandom};
        // lean on the sign and wrap corners now and then
        case ($urandom_range(0, 11))
            0:       r.tv = 64'sh0;
            1:       r.tv = -64'sd1;
            2:       r.tv = {1'b1, 63'b0};
            3:       r.tv = {1'b0, {63{1'b1}}};
            default: ;
        endcase
        r.dir = byte_t'($urandom);
        r.spd = $urandom;
        if ($urandom_range(0, 7) == 0)
            r.spd = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        for (k = 0; k < 6; k++)
            r.gains[k] = byte_t'($urandom_range(0, 255));
        return r;
    endfunction

    // optional idle burst, then offer one beat and hold it until taken
    task automatic send_request(input motor_req_t r);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= r.op;
        target_value <= r.tv;
        direction    <= r.dir;
        max_speed    <= r.spd;
        gain_pos_p   <= r.gains[0];
        gain_pos_i   <= r.gains[1];
        gain_vel_p   <= r.gains[2];
        gain_vel_i   <= r.gains[3];
        gain_trq_p   <= r.gains[4];
        gain_trq_i   <= r.gains[5];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drive address write, only once the block has drained
    task automatic write_drive_addr(input byte_t id);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        // an unused-code request leaves nothing in flight to wait on, so settle
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= id;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // random requests; unused codes are thrown in but not counted
    task automatic random_phase(input int n_frames);
        motor_req_t r;
        int         sent;
        int         pick;
        sent = 0;
        while (sent < n_frames)
        begin
            pick = $urandom_range(0, 39);
            if (pick < 2)
                r = rand_req(op_code_t'(4'd14 + pick));
            else
                r = rand_req(op_code_t'($urandom_range(0, 13)));
            send_request(r);
            if (r.op <= OP_INCR2)
                sent++;
        end
    endtask

    // receiver: random stall bursts, one long hold-off, none at the end
    initial
    begin : receiver
        int  burst;
        bit  hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                out_stall <= 1'b0;
            end
            else if (hold_off_due && !hold_done)
            begin
                // counted here while the sender keeps offering, so input backs up
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                burst = $urandom_range(1, 14);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (burst - 1) @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        motor_req_t r;
        int         drain;
        calm           = 1'b0;
        hold_off_due   = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = '0;
        target_value   = '0;
        direction      = '0;
        max_speed      = '0;
        gain_pos_p     = '0;
        gain_pos_i     = '0;
        gain_vel_p     = '0;
        gain_vel_i     = '0;
        gain_trq_p     = '0;
        gain_trq_i     = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, motor id still at its reset value
        // gains all ones so the payload checksum wraps
        r = rand_req(OP_PID_RAM); r.gains = '1; send_request(r);
        r = rand_req(OP_PID_ROM); r.gains = '0; send_request(r);
        // header-only frames; payload fields carry junk that must be ignored
        send_request(rand_req(OP_STOP));
        send_request(rand_req(OP_PAUSE));
        send_request(rand_req(OP_RESUME));
        send_request(rand_req(OP_READ));
        // value extremes, only the low bytes may leave for power and velocity
        r = rand_req(OP_POWER);   r.tv = {1'b0, {63{1'b1}}}; send_request(r);
        r = rand_req(OP_POWER);   r.tv = {1'b1, 63'b0};      send_request(r);
        r = rand_req(OP_VEL);     r.tv = -64'sd1;            send_request(r);
        r = rand_req(OP_VEL);     r.tv = 64'sh0;             send_request(r);
        r = rand_req(OP_MULTI1);  r.tv = {1'b1, 63'b0};      send_request(r);
        r = rand_req(OP_MULTI1);  r.tv = {1'b0, {63{1'b1}}}; send_request(r);
        // longest frame, all ones
        r = rand_req(OP_MULTI2);  r.tv = -64'sd1; r.spd = 32'hFFFF_FFFF; send_request(r);
        r = rand_req(OP_MULTI2);  r.tv = 64'sh0;  r.spd = 32'h0;         send_request(r);
        r = rand_req(OP_SINGLE1); r.tv = -64'sd1; r.dir = 8'hFF;         send_request(r);
        r = rand_req(OP_SINGLE1); r.tv = 64'sh1234; r.dir = 8'h00;       send_request(r);
        r = rand_req(OP_SINGLE2);
        r.tv = {1'b1, 63'b0}; r.dir = 8'hFF; r.spd = 32'hFFFF_FFFF;
        send_request(r);
        r = rand_req(OP_INCR1);   r.tv = 64'sh8000_0000;                 send_request(r);
        r = rand_req(OP_INCR2);   r.tv = -64'sd1; r.spd = 32'hFFFF_FFFF; send_request(r);
        r = rand_req(OP_INCR2);   r.tv = 64'sh0;  r.spd = 32'h0;         send_request(r);
        // unused codes: taken, no bytes, a frame right after must be clean
        send_request(rand_req(op_code_t'(4'd14)));
        send_request(rand_req(op_code_t'(4'd15)));
        send_request(rand_req(OP_STOP));

        // random part over several drive addresses, low extreme first
        write_drive_addr(8'h00);
        hold_off_due = 1'b1;
        random_phase(30);

        write_drive_addr(8'hFF);
        random_phase(30);

        write_drive_addr(byte_t'($urandom_range(0, 255)));
        random_phase(25);

        // last stretch with no idling anywhere
        write_drive_addr(byte_t'($urandom_range(0, 255)));
        calm = 1'b1;
        random_phase(25);

        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending != 0)
            $display("%0t: %0d expected frame bytes never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
